>>> sv/cpbh_pkg.sv
// ----------------------------------------------------------------------------
// Convex polygon hit test - shared package
// Default sizes, command and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cpbh_pkg;

  localparam int DEF_MAX_BUTTONS = 16;
  localparam int DEF_MAX_VERTS   = 8;
  localparam int DEF_COORD_BITS  = 8;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 1'b1;

  localparam int CMD_W  = 2;
  localparam int BIDX_W = 4;   // button_index / hit_button field width
  localparam int VIDX_W = 3;   // vertex_index field width
  localparam int VCNT_W = 4;   // vertex_count field width
  localparam int BCNT_W = 5;   // button_count register width
  localparam int OFS_W  = 6;   // center_offset register width

  // compare widths: hold MAX_BUTTONS (<= 64) and MAX_VERTS (<= 32)
  localparam int BTN_CMP_W = 7;
  localparam int VTX_CMP_W = 6;

  // cycles from the last read issue until the verdict registers settle
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_VERT = 2'd0,
    CMD_WR_CNT  = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic wr_vert;   // store vertex of the current beat
    logic wr_cnt;    // store vertex count of the current beat
    logic q_start;   // latch query point, reset scan and verdict
    logic issue;     // step the scan, one vertex read
    logic load;      // move verdict into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic limit_zero;  // no buttons to test
    logic btn_last;    // scan sits on the last tested button
    logic btn_done;    // this issue finishes the current button
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/convex_polygon_button_hit_test_core.sv
// ----------------------------------------------------------------------------
// Convex polygon button hit test - top level
// Polygon table with edge-by-edge point containment test.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the command (vertex write, count write,
//   query). Writes complete in the beat they are accepted and give no
//   output. A query returns one beat on the output stream: hit flag and
//   index of the highest-numbered polygon that is empty or holds the point.
//   Config port: button_count (index 0), center_offset (index 1); write
//   only while the block is idle.
//   Query: each tested button takes one vertex read per vertex plus one
//   for the closing edge (a single read when its vertex count is zero),
//   then the verdict drains through the pipeline and is loaded into the
//   output register; the single vertex store read port gives one vertex
//   per cycle. One query in flight at a time; writes are accepted back to
//   back while idle.
//   Reset clears the control, config and verdict registers and vertex
//   counts (every polygon empty); coordinates are undefined until written.
//   A stalled output holds its beat; a new item is still accepted, and a
//   following query waits at its end for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_button_hit_test_core
  import cpbh_pkg::*;
#(
  parameter int MAX_BUTTONS = DEF_MAX_BUTTONS,
  parameter int MAX_VERTS   = DEF_MAX_VERTS,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  localparam int IN_BITS    = BIDX_W + VIDX_W + 2 * COORD_BITS + VCNT_W,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // button_index, vertex_index, coord_x, coord_y, vertex_count
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]      s_axis_tuser,
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // hit, hit_button
  output logic [7:0]                 m_axis_tdata
);

  localparam int VI_LSB = BIDX_W;
  localparam int CX_LSB = VI_LSB + VIDX_W;
  localparam int CY_LSB = CX_LSB + COORD_BITS;
  localparam int VC_LSB = CY_LSB + COORD_BITS;

  logic [BIDX_W-1:0]            in_button_index;
  logic [VIDX_W-1:0]            in_vertex_index;
  logic signed [COORD_BITS-1:0] in_coord_x, in_coord_y;
  logic [VCNT_W-1:0]            in_vertex_count;

  assign in_button_index = s_axis_tdata[BIDX_W-1:0];
  assign in_vertex_index = s_axis_tdata[VI_LSB +: VIDX_W];
  assign in_coord_x      = s_axis_tdata[CX_LSB +: COORD_BITS];
  assign in_coord_y      = s_axis_tdata[CY_LSB +: COORD_BITS];
  assign in_vertex_count = s_axis_tdata[VC_LSB +: VCNT_W];

  dp_cmd_t           ctrl_cmd;
  dp_stat_t          dp_stat;
  logic              res_hit;
  logic [BIDX_W-1:0] res_btn;

  cpbh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_cmd_i    (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  cpbh_dp #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .MAX_VERTS   (MAX_VERTS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .button_index_i (in_button_index),
    .vertex_index_i (in_vertex_index),
    .coord_x_i      (in_coord_x),
    .coord_y_i      (in_coord_y),
    .vertex_count_i (in_vertex_count),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .hit_o          (res_hit),
    .hit_button_o   (res_btn)
  );

  assign m_axis_tdata = {3'b000, res_btn, res_hit};

`ifndef SYNTHESIS
  // no new beat is taken while the scan is reading the vertex store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.issue |-> !s_axis_tready)
    else $error("input accepted during scan");

  // a miss reports button zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == 4'd0))
    else $error("miss with non-zero button index");

  // a verdict never overwrites a result still waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> sv/cpbh_ctrl.sv
// ----------------------------------------------------------------------------
// Convex polygon hit test - controller
// Input handshake, scan sequencing, pipeline drain and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbh_ctrl
  import cpbh_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic [CMD_W-1:0] s_cmd_i,
  output logic                  s_tready_o,
  input  wire logic             m_tready_i,
  output logic                  m_tvalid_o,
  input  wire dp_stat_t         stat_i,
  output dp_cmd_t               cmd_o
);

  ctrl_state_e        state_q, state_d;
  logic [DRAIN_W-1:0] drain_q, drain_d;
  logic               m_tvalid_q, m_tvalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      drain_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      drain_q    <= drain_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    drain_d    = drain_q;
    m_tvalid_d = m_tvalid_q & ~m_tready_i;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          case (s_cmd_i)
            CMD_WR_VERT: cmd_o.wr_vert = 1'b1;
            CMD_WR_CNT:  cmd_o.wr_cnt  = 1'b1;
            CMD_QUERY: begin
              cmd_o.q_start = 1'b1;
              drain_d       = '0;
              state_d       = stat_i.limit_zero ? ST_DRAIN : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.btn_last && stat_i.btn_done) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (!m_tvalid_q || m_tready_i) begin
          cmd_o.load = 1'b1;
          m_tvalid_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_tvalid_o = m_tvalid_q;

endmodule

`default_nettype wire

>>> sv/cpbh_dp.sv
// ----------------------------------------------------------------------------
// Convex polygon hit test - datapath
// Config registers, vertex store, count table, scan counters and the
// edge test pipeline (read, differences, products, sign and verdict).
// ----------------------------------------------------------------------------
`default_nettype none

module cpbh_dp
  import cpbh_pkg::*;
#(
  parameter int MAX_BUTTONS = DEF_MAX_BUTTONS,
  parameter int MAX_VERTS   = DEF_MAX_VERTS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  wire logic [BIDX_W-1:0]            button_index_i,
  input  wire logic [VIDX_W-1:0]            vertex_index_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic [VCNT_W-1:0]            vertex_count_i,
  input  wire dp_cmd_t                      cmd_i,
  output dp_stat_t                          stat_o,
  output logic                              hit_o,
  output logic [BIDX_W-1:0]                 hit_button_o
);

  localparam int BTN_W  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int VIX_W  = $clog2(MAX_VERTS);
  localparam int CNT_W  = $clog2(MAX_VERTS + 1);
  localparam int DEPTH  = MAX_BUTTONS * MAX_VERTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PW     = COORD_BITS + 1;   // centred point, edge deltas
  localparam int DW     = COORD_BITS + 2;   // point minus vertex
  localparam int PRW    = PW + DW;          // product
  localparam int SW     = PRW + 1;          // sum of products

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             edge_ok;
    logic             last;
    logic             empty;
    logic [BTN_W-1:0] btn;
  } tag_t;

  // ---------------- config registers ----------------
  logic [BCNT_W-1:0] button_count_q;
  logic [OFS_W-1:0]  center_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q  <= '0;
      center_offset_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BUTTON_COUNT) begin
        button_count_q <= cfg_data_i[BCNT_W-1:0];
      end
      if (cfg_idx_i == CFG_CENTER_OFFSET) begin
        center_offset_q <= cfg_data_i[OFS_W-1:0];
      end
    end
  end

  // ---------------- write decode ----------------
  logic                 bi_ok, vi_ok;
  logic [VTX_CMP_W-1:0] vc_ext, vc_sat;
  logic [ADDR_W-1:0]    wr_addr;

  assign bi_ok   = BTN_CMP_W'(button_index_i) < BTN_CMP_W'(MAX_BUTTONS);
  assign vi_ok   = VTX_CMP_W'(vertex_index_i) < VTX_CMP_W'(MAX_VERTS);
  assign vc_ext  = VTX_CMP_W'(vertex_count_i);
  assign vc_sat  = (vc_ext > VTX_CMP_W'(MAX_VERTS)) ? VTX_CMP_W'(MAX_VERTS) : vc_ext;
  assign wr_addr = ADDR_W'(button_index_i) * ADDR_W'(MAX_VERTS) + ADDR_W'(vertex_index_i);

  // ---------------- vertex count table ----------------
  logic [CNT_W-1:0] counts_q [MAX_BUTTONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BUTTONS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (cmd_i.wr_cnt && bi_ok) begin
      counts_q[BTN_W'(button_index_i)] <= CNT_W'(vc_sat);
    end
  end

  // ---------------- scan counters ----------------
  logic [BTN_W-1:0]     btn_q;
  logic [CNT_W-1:0]     vtx_q;
  logic [CNT_W-1:0]     n_cur;
  logic                 empty, vend;
  logic [VIX_W-1:0]     slot;
  logic [ADDR_W-1:0]    rd_addr;
  logic [BTN_CMP_W-1:0] limit;

  assign n_cur   = counts_q[btn_q];
  assign empty   = (n_cur == '0);
  assign vend    = (vtx_q == n_cur);
  // closing edge reads vertex 0 again
  assign slot    = vend ? '0 : VIX_W'(vtx_q);
  assign rd_addr = ADDR_W'(btn_q) * ADDR_W'(MAX_VERTS) + ADDR_W'(slot);
  assign limit   = (BTN_CMP_W'(button_count_q) > BTN_CMP_W'(MAX_BUTTONS)) ?
                   BTN_CMP_W'(MAX_BUTTONS) : BTN_CMP_W'(button_count_q);

  assign stat_o.limit_zero = (limit == '0);
  assign stat_o.btn_last   = ((BTN_CMP_W'(btn_q) + BTN_CMP_W'(1)) == limit);
  assign stat_o.btn_done   = empty | vend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q <= '0;
      vtx_q <= '0;
    end else if (cmd_i.q_start) begin
      btn_q <= '0;
      vtx_q <= '0;
    end else if (cmd_i.issue) begin
      if (empty || vend) begin
        vtx_q <= '0;
        if (!stat_o.btn_last) begin
          btn_q <= btn_q + 1'b1;
        end
      end else begin
        vtx_q <= vtx_q + 1'b1;
      end
    end
  end

  // ---------------- vertex store ----------------
  logic signed [COORD_BITS-1:0] mem_x [DEPTH];
  logic signed [COORD_BITS-1:0] mem_y [DEPTH];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_vert && bi_ok && vi_ok) begin
      mem_x[wr_addr] <= coord_x_i;
      mem_y[wr_addr] <= coord_y_i;
    end
    if (cmd_i.issue) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  // ---------------- query point ----------------
  logic signed [PW-1:0] px_q, py_q;
  logic signed [PW-1:0] ofs_s;

  assign ofs_s = PW'($signed({1'b0, center_offset_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      px_q <= PW'(coord_x_i) - ofs_s;
      py_q <= PW'(coord_y_i) - ofs_s;
    end
  end

  // ---------------- edge pipeline ----------------
  tag_t s1_q, s2_q, s3_q, s1_d;

  always_comb begin
    s1_d         = '0;
    s1_d.valid   = cmd_i.issue;
    s1_d.empty   = cmd_i.issue & empty;
    s1_d.first   = cmd_i.issue & ~empty & (vtx_q == '0);
    s1_d.edge_ok = cmd_i.issue & ~empty & (vtx_q != '0);
    s1_d.last    = cmd_i.issue & ~empty & vend;
    s1_d.btn     = btn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // stage 1: edge vector and offsets from the new vertex
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [PW-1:0]         a_q, b_q;
  logic signed [DW-1:0]         dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    a_q  <= PW'(prev_y_q) - PW'(rd_y_q);
    b_q  <= PW'(rd_x_q) - PW'(prev_x_q);
    dx_q <= DW'(px_q) - DW'(rd_x_q);
    dy_q <= DW'(py_q) - DW'(rd_y_q);
  end

  // stage 2: products
  logic signed [PRW-1:0] p1_q, p2_q;

  always_ff @(posedge clk_i) begin
    p1_q <= PRW'(a_q) * PRW'(dx_q);
    p2_q <= PRW'(b_q) * PRW'(dy_q);
  end

  // stage 3: sign of the cross product and per-button verdict
  logic signed [SW-1:0] sum;
  logic                 ok_q, ok_now;
  logic                 hit_q;
  logic [BTN_W-1:0]     found_q;

  assign sum    = SW'(p1_q) + SW'(p2_q);
  assign ok_now = ok_q & ~sum[SW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q    <= 1'b0;
      hit_q   <= 1'b0;
      found_q <= '0;
    end else if (cmd_i.q_start) begin
      hit_q   <= 1'b0;
      found_q <= '0;
    end else begin
      if (s3_q.first) begin
        ok_q <= 1'b1;
      end else if (s3_q.edge_ok) begin
        ok_q <= ok_now;
      end
      // later buttons override earlier ones
      if (s3_q.empty || (s3_q.last && ok_now)) begin
        hit_q   <= 1'b1;
        found_q <= s3_q.btn;
      end
    end
  end

  // ---------------- output register ----------------
  logic              res_hit_q;
  logic [BIDX_W-1:0] res_btn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_hit_q <= hit_q;
      res_btn_q <= BIDX_W'(found_q);
    end
  end

  assign hit_o        = res_hit_q;
  assign hit_button_o = res_btn_q;

endmodule

`default_nettype wire
